// ----- design/tpbd_pkg.sv -----
`timescale 1ns / 1ps

package tpbd_pkg;

	// number of touch pads held in the state arrays
	localparam int PAD_COUNT = 8;
	localparam int PAD_W     = 3;

	// field widths
	localparam int CNT_W  = 16;
	localparam int GAIN_W = 17;
	localparam int BASE_W = 33;
	localparam int DEB_W  = 8;
	localparam int BINT_W = BASE_W - 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// register reset values
	localparam logic [CNT_W-1:0]  PRESS_MARGIN_RST   = 16'd150;
	localparam logic [CNT_W-1:0]  RELEASE_MARGIN_RST = 16'd100;
	localparam logic [DEB_W-1:0]  DEBOUNCE_RST       = 8'd1;
	localparam logic [GAIN_W-1:0] FILTER_GAIN_RST    = 17'd16384;
	localparam logic [GAIN_W-1:0] TRACK_GAIN_RST     = 17'd327;
	localparam logic [GAIN_W-1:0] INIT_GAIN_RST      = 17'd68812;

	// command codes
	typedef enum logic [1:0] {
		CMD_SAMPLE    = 2'd0,
		CMD_CALIBRATE = 2'd1,
		CMD_EVALUATE  = 2'd2
	} cmd_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESS_MARGIN   = 3'd0,
		REG_RELEASE_MARGIN = 3'd1,
		REG_DEBOUNCE_LIMIT = 3'd2,
		REG_FILTER_GAIN    = 3'd3,
		REG_TRACK_GAIN     = 3'd4,
		REG_INIT_GAIN      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0]  press_margin;
		logic [CNT_W-1:0]  release_margin;
		logic [DEB_W-1:0]  debounce_limit;
		logic [GAIN_W-1:0] filter_gain;
		logic [GAIN_W-1:0] track_gain;
		logic [GAIN_W-1:0] init_gain;
	} cfg_t;

	// per-pad state as seen by the update logic
	typedef struct packed {
		logic [CNT_W-1:0]  filt;
		logic [BASE_W-1:0] base;
		logic [DEB_W-1:0]  deb;
		logic              touched;
	} pad_state_t;

endpackage

// ----- design/tpbd_update.sv -----
`timescale 1ns / 1ps

// Next state of one pad for one command; one shared multiplier.
module tpbd_update import tpbd_pkg::*; (
	input  logic [1:0]        command,
	input  logic [CNT_W-1:0]  raw_count,
	input  cfg_t              cfg,
	input  pad_state_t        cur,
	output pad_state_t        nxt,
	output logic              changed
);

	logic [BINT_W-1:0]  base_int;
	logic signed [17:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [35:0] prod;
	logic signed [20:0] filt_sum;
	logic signed [36:0] base_sum;
	logic [17:0]        press_thr;
	logic [17:0]        release_thr;
	logic               press_hit;
	logic               release_hit;
	logic               deb_done;
	logic [DEB_W-1:0]   deb_inc;

	assign base_int = cur.base[BASE_W-1:16];

	// operand select for the shared multiplier
	always_comb begin
		case (command)
			CMD_SAMPLE: begin
				mul_a = $signed({2'b00, raw_count}) - $signed({2'b00, cur.filt});
				mul_b = $signed({1'b0, cfg.filter_gain});
			end
			CMD_CALIBRATE: begin
				mul_a = $signed({2'b00, cur.filt});
				mul_b = $signed({1'b0, cfg.init_gain});
			end
			default: begin
				mul_a = $signed({2'b00, cur.filt}) - $signed({1'b0, base_int});
				mul_b = $signed({1'b0, cfg.track_gain});
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// filter step: floor of product / 2^16 is the arithmetic shift
	assign filt_sum = $signed({5'b00000, cur.filt}) + $signed({prod[35], prod[35:16]});

	// baseline tracking sum
	assign base_sum = $signed({4'b0000, cur.base}) + $signed({prod[35], prod});

	// hysteresis thresholds
	assign press_thr   = {1'b0, base_int} + {2'b00, cfg.press_margin};
	assign release_thr = {1'b0, base_int} + {2'b00, cfg.release_margin};
	assign press_hit   = {2'b00, cur.filt} > press_thr;
	assign release_hit = {2'b00, cur.filt} < release_thr;

	assign deb_done = cur.deb >= cfg.debounce_limit;
	assign deb_inc  = cur.deb + 1'b1;

	always_comb begin
		nxt     = cur;
		changed = 1'b0;
		case (command)
			CMD_SAMPLE: begin
				if (filt_sum < 0) begin
					nxt.filt = '0;
				end else if (filt_sum > 21'sd65535) begin
					nxt.filt = '1;
				end else begin
					nxt.filt = filt_sum[CNT_W-1:0];
				end
			end
			CMD_CALIBRATE: begin
				nxt.base = prod[BASE_W-1:0];
			end
			CMD_EVALUATE: begin
				if (!cur.touched) begin
					if (press_hit) begin
						nxt.deb = deb_done ? '0 : deb_inc;
						if (deb_done) begin
							nxt.touched = 1'b1;
							changed     = 1'b1;
						end
					end else begin
						nxt.deb = '0;
						// saturate the tracked baseline to its store
						if (base_sum < 0) begin
							nxt.base = '0;
						end else if (base_sum[36:BASE_W] != '0) begin
							nxt.base = '1;
						end else begin
							nxt.base = base_sum[BASE_W-1:0];
						end
					end
				end else begin
					if (release_hit) begin
						nxt.deb = deb_done ? '0 : deb_inc;
						if (deb_done) begin
							nxt.touched = 1'b0;
							changed     = 1'b1;
						end
					end else begin
						nxt.deb = '0;
					end
				end
			end
			default: begin
				nxt     = cur;
				changed = 1'b0;
			end
		endcase
	end

endmodule

// ----- design/touch_pad_baseline_detector.sv -----
`timescale 1ns / 1ps

// Stages: input register, then result register; the status outputs are registered.
// One item per cycle while the status side does not stall; the pad state update and the one
// shared multiply sit between the input register and the result register.
// Reset (arst_n low, asynchronous): pad state, key bits and debounce counts clear to
// zero, configuration registers take their default values, both stages go empty.
module touch_pad_baseline_detector import tpbd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// command channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            command,
	input  logic [2:0]            pad_index,
	input  logic [CNT_W-1:0]      raw_count,
	// status channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            key_status,
	output logic                  pad_touched,
	output logic                  state_changed,
	output logic [CNT_W-1:0]      filtered_level,
	output logic [BINT_W-1:0]     baseline_level
);

	cfg_t              cfg_q;
	logic [CNT_W-1:0]  filt_q  [PAD_COUNT];
	logic [BASE_W-1:0] base_q  [PAD_COUNT];
	logic [DEB_W-1:0]  deb_q   [PAD_COUNT];
	logic [PAD_COUNT-1:0] touched_q;

	logic              valid_s1;
	logic [1:0]        cmd_s1;
	logic [2:0]        pad_s1;
	logic [CNT_W-1:0]  raw_s1;
	logic              valid_s2;

	logic              in_take;
	logic              advance;
	logic              pad_ok;
	logic [PAD_W-1:0]  pad_sel;
	pad_state_t        cur;
	pad_state_t        nxt;
	logic              changed;
	logic [PAD_COUNT-1:0] touched_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_margin   <= PRESS_MARGIN_RST;
			cfg_q.release_margin <= RELEASE_MARGIN_RST;
			cfg_q.debounce_limit <= DEBOUNCE_RST;
			cfg_q.filter_gain    <= FILTER_GAIN_RST;
			cfg_q.track_gain     <= TRACK_GAIN_RST;
			cfg_q.init_gain      <= INIT_GAIN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PRESS_MARGIN:   cfg_q.press_margin   <= cfg_data[CNT_W-1:0];
				REG_RELEASE_MARGIN: cfg_q.release_margin <= cfg_data[CNT_W-1:0];
				REG_DEBOUNCE_LIMIT: cfg_q.debounce_limit <= cfg_data[DEB_W-1:0];
				REG_FILTER_GAIN:    cfg_q.filter_gain    <= cfg_data[GAIN_W-1:0];
				REG_TRACK_GAIN:     cfg_q.track_gain     <= cfg_data[GAIN_W-1:0];
				REG_INIT_GAIN:      cfg_q.init_gain      <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on whenever the result register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1 <= command;
			pad_s1 <= pad_index;
			raw_s1 <= raw_count;
		end
	end

	// addressed pad state
	assign pad_ok  = {29'd0, pad_s1} < PAD_COUNT;
	assign pad_sel = pad_s1[PAD_W-1:0];

	always_comb begin
		cur.filt    = filt_q[pad_sel];
		cur.base    = base_q[pad_sel];
		cur.deb     = deb_q[pad_sel];
		cur.touched = touched_q[pad_sel];
	end

	tpbd_update u_update (
		.command   (cmd_s1),
		.raw_count (raw_s1),
		.cfg       (cfg_q),
		.cur       (cur),
		.nxt       (nxt),
		.changed   (changed)
	);

	always_comb begin
		touched_next = touched_q;
		if (pad_ok) begin
			touched_next[pad_sel] = nxt.touched;
		end
	end

	// pad state write-back on the stage 1 transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAD_COUNT; i++) begin
				filt_q[i] <= '0;
				base_q[i] <= '0;
				deb_q[i]  <= '0;
			end
			touched_q <= '0;
		end else if (advance && pad_ok) begin
			filt_q[pad_sel] <= nxt.filt;
			base_q[pad_sel] <= nxt.base;
			deb_q[pad_sel]  <= nxt.deb;
			touched_q       <= touched_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_status     <= touched_next[7:0];
			pad_touched    <= pad_ok & nxt.touched;
			state_changed  <= pad_ok & changed;
			filtered_level <= pad_ok ? nxt.filt : '0;
			baseline_level <= pad_ok ? nxt.base[BASE_W-1:16] : '0;
		end
	end

	assign out_valid = valid_s2;

	// checks
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with stage 1 empty");

	a_change_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pad_ok && changed) |=> touched_q != $past(touched_q))
		else $error("key bit change reported but not stored");

	a_filter_only_on_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pad_ok && cmd_s1 != CMD_SAMPLE)
		|=> filt_q[$past(pad_sel)] == $past(cur.filt))
		else $error("filtered count moved on a non-sample command");

endmodule

// ----- tb/touch_board_pkg.sv -----
`timescale 1ns / 1ps

package touch_board_pkg;
	import tpbd_pkg::*;

	localparam longint BASE_MAX = (longint'(1) << BASE_W) - 1;

	// one status transfer as the block returns it
	typedef struct packed {
		logic [7:0]        keys;
		logic              touched;
		logic              changed;
		logic [CNT_W-1:0]  filt;
		logic [BINT_W-1:0] base_int;
	} status_t;

	// Tracks the pad state alongside the block and holds the status words still due.
	class touch_status_board;
		logic [CNT_W-1:0]     press_margin;
		logic [CNT_W-1:0]     release_margin;
		logic [DEB_W-1:0]     debounce_limit;
		logic [GAIN_W-1:0]    filter_gain;
		logic [GAIN_W-1:0]    track_gain;
		logic [GAIN_W-1:0]    init_gain;
		logic [CNT_W-1:0]     filt [PAD_COUNT];
		logic [BASE_W-1:0]    base [PAD_COUNT];
		logic [DEB_W-1:0]     deb [PAD_COUNT];
		logic [PAD_COUNT-1:0] touched;
		status_t              status_due[$];
		int                   mismatches;

		function new();
			press_margin   = PRESS_MARGIN_RST;
			release_margin = RELEASE_MARGIN_RST;
			debounce_limit = DEBOUNCE_RST;
			filter_gain    = FILTER_GAIN_RST;
			track_gain     = TRACK_GAIN_RST;
			init_gain      = INIT_GAIN_RST;
			foreach (filt[i]) begin
				filt[i] = '0;
				base[i] = '0;
				deb[i]  = '0;
			end
			touched    = '0;
			mismatches = 0;
		endfunction

		function void report(string what);
			$display("mismatch at %0t ns: %s", $time, what);
			mismatches++;
		endfunction

		function int pending();
			return status_due.size();
		endfunction

		// excess bits of the write data are dropped by the field width
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PRESS_MARGIN:   press_margin   = data[CNT_W-1:0];
				REG_RELEASE_MARGIN: release_margin = data[CNT_W-1:0];
				REG_DEBOUNCE_LIMIT: debounce_limit = data[DEB_W-1:0];
				REG_FILTER_GAIN:    filter_gain    = data[GAIN_W-1:0];
				REG_TRACK_GAIN:     track_gain     = data[GAIN_W-1:0];
				REG_INIT_GAIN:      init_gain      = data[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// one more hit; true once the hit run is long enough
		function bit debounce_done(int p);
			if (deb[p] >= debounce_limit) begin
				deb[p] = '0;
				return 1'b1;
			end
			deb[p] = deb[p] + 1'b1;
			return 1'b0;
		endfunction

		// update the pad state for one accepted command and queue the status it yields
		function void take_command(logic [1:0] cmd, logic [2:0] pad, logic [CNT_W-1:0] raw);
			status_t s;
			longint  fl;
			longint  bint;
			longint  nf;
			longint  nb;
			int      p;
			bit      changed;
			s = '0;
			changed = 1'b0;
			p = int'(pad);
			if (p < PAD_COUNT) begin
				fl   = longint'(filt[p]);
				bint = longint'(base[p] >> 16);
				case (cmd)
					CMD_SAMPLE: begin
						// arithmetic shift gives the floor of the signed step
						nf = fl + (((longint'(raw) - fl) * longint'(filter_gain)) >>> 16);
						if (nf < 0)
							nf = 0;
						if (nf > 65535)
							nf = 65535;
						filt[p] = nf[CNT_W-1:0];
					end
					CMD_CALIBRATE: begin
						nb = fl * longint'(init_gain);
						base[p] = nb[BASE_W-1:0];
					end
					CMD_EVALUATE: begin
						if (!touched[p]) begin
							if (fl > bint + longint'(press_margin)) begin
								if (debounce_done(p)) begin
									touched[p] = ~touched[p];
									changed = 1'b1;
								end
							end else begin
								// released and quiet: baseline follows the filtered count
								deb[p] = '0;
								nb = longint'(base[p]) + (fl - bint) * longint'(track_gain);
								if (nb < 0)
									nb = 0;
								if (nb > BASE_MAX)
									nb = BASE_MAX;
								base[p] = nb[BASE_W-1:0];
							end
						end else begin
							if (fl < bint + longint'(release_margin)) begin
								if (debounce_done(p)) begin
									touched[p] = ~touched[p];
									changed = 1'b1;
								end
							end else begin
								deb[p] = '0;
							end
						end
					end
					default: ;
				endcase
				s.touched  = touched[p];
				s.changed  = changed;
				s.filt     = filt[p];
				s.base_int = base[p][BASE_W-1:16];
			end
			s.keys = 8'(touched);
			status_due.push_back(s);
		endfunction

		function void check_status(status_t got);
			status_t want;
			if (status_due.size() == 0) begin
				report($sformatf("status %h with no command waiting", got));
				return;
			end
			want = status_due.pop_front();
			if (got.keys !== want.keys)
				report($sformatf("key_status %h, expected %h", got.keys, want.keys));
			if (got.touched !== want.touched)
				report($sformatf("pad_touched %b, expected %b", got.touched, want.touched));
			if (got.changed !== want.changed)
				report($sformatf("state_changed %b, expected %b", got.changed, want.changed));
			if (got.filt !== want.filt)
				report($sformatf("filtered_level %0d, expected %0d", got.filt, want.filt));
			if (got.base_int !== want.base_int)
				report($sformatf("baseline_level %0d, expected %0d",
					got.base_int, want.base_int));
		endfunction
	endclass

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import tpbd_pkg::*;
	import touch_board_pkg::*;

	localparam logic [1:0]           CMD_UNKNOWN = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam int SETTLE      = 4;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            command = '0;
	logic [2:0]            pad_index = '0;
	logic [CNT_W-1:0]      raw_count = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            key_status;
	logic                  pad_touched;
	logic                  state_changed;
	logic [CNT_W-1:0]      filtered_level;
	logic [BINT_W-1:0]     baseline_level;

	touch_status_board board;
	bit                steady;
	int                rest_level [PAD_COUNT];
	int                lift [PAD_COUNT];
	bit                touch_on [PAD_COUNT];
	int                cycle_count;

	touch_pad_baseline_detector dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.pad_index      (pad_index),
		.raw_count      (raw_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.key_status     (key_status),
		.pad_touched    (pad_touched),
		.state_changed  (state_changed),
		.filtered_level (filtered_level),
		.baseline_level (baseline_level)
	);

	always #2 clk = ~clk;

	// idle cycles before the next transfer on either side
	function automatic int draw_gap();
		if (steady || $urandom_range(0, 9) < 4)
			return 0;
		return $urandom_range(1, 17);
	endfunction

	// present one command and hold it until the block takes it
	task automatic send_item(input logic [1:0] cmd, input logic [2:0] pad,
			input logic [CNT_W-1:0] raw);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		pad_index <= pad;
		raw_count <= raw;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.take_command(cmd, pad, raw);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	// stop sending and let every status word come back
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (board.pending() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// status side: check each transfer, then stall for a random stretch
	initial begin : status_sink
		int      hold;
		status_t got;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && !out_stall) begin
				got.keys     = key_status;
				got.touched  = pad_touched;
				got.changed  = state_changed;
				got.filt     = filtered_level;
				got.base_int = baseline_level;
				board.check_status(got);
				hold = draw_gap();
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] pm, rm, dl, fg, tg, ig;
		logic [1:0]            cmd;
		int                    p, k, v;
		board = new();
		steady = 1'b0;
		foreach (rest_level[i]) begin
			rest_level[i] = $urandom_range(300, 30000);
			lift[i]       = $urandom_range(200, 4000);
			touch_on[i]   = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: untouched pad, unknown command, field extremes
		send_item(CMD_EVALUATE, 3'd0, 16'h1234);
		send_item(CMD_UNKNOWN, 3'd1, 16'hFFFF);
		repeat (2) send_item(CMD_SAMPLE, 3'd7, 16'hFFFF);
		send_item(CMD_CALIBRATE, 3'd7, 16'h0000);
		send_item(CMD_EVALUATE, 3'd7, 16'hFFFF);
		// filtered count below baseline pulls the baseline down
		send_item(CMD_SAMPLE, 3'd7, 16'h0000);
		send_item(CMD_EVALUATE, 3'd7, 16'h0000);
		// settle, calibrate, press and release one pad
		repeat (4) send_item(CMD_SAMPLE, 3'd3, 16'd2000);
		send_item(CMD_CALIBRATE, 3'd3, 16'hAAAA);
		repeat (3) send_item(CMD_SAMPLE, 3'd3, 16'd5000);
		repeat (2) send_item(CMD_EVALUATE, 3'd3, 16'h5555);
		repeat (3) send_item(CMD_SAMPLE, 3'd3, 16'd0);
		repeat (2) send_item(CMD_EVALUATE, 3'd3, 16'h0000);
		// debounce limit dropped under a running hit count
		wait_drain();
		write_reg(REG_DEBOUNCE_LIMIT, 17'd3);
		cfg_write <= 1'b0;
		repeat (2) send_item(CMD_SAMPLE, 3'd5, 16'd5000);
		repeat (2) send_item(CMD_EVALUATE, 3'd5, 16'd0);
		wait_drain();
		write_reg(REG_DEBOUNCE_LIMIT, 17'd0);
		cfg_write <= 1'b0;
		send_item(CMD_EVALUATE, 3'd5, 16'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drain();
			// register settings: defaults, extremes, then random ones
			case (ph)
				0: begin
					pm = CFG_DATA_W'(PRESS_MARGIN_RST);
					rm = CFG_DATA_W'(RELEASE_MARGIN_RST);
					dl = CFG_DATA_W'(DEBOUNCE_RST);
					fg = FILTER_GAIN_RST;
					tg = TRACK_GAIN_RST;
					ig = INIT_GAIN_RST;
				end
				1: begin
					pm = '0; rm = '0; dl = '0; fg = '0; tg = '0; ig = '0;
				end
				2: begin
					pm = '1; rm = '1; dl = '1; fg = '1; tg = '1; ig = '1;
				end
				3: begin
					pm = '0;
					rm = 17'h0FFFF;
					dl = '0;
					fg = 17'd65536;
					tg = 17'd65536;
					ig = 17'd65536;
				end
				4: begin
					pm = 17'h1FFFF;
					rm = '0;
					dl = 17'd255;
					fg = 17'd131071;
					tg = 17'd131071;
					ig = 17'd131071;
				end
				default: begin
					pm = 17'($urandom_range(20, 2000));
					rm = 17'($urandom_range(0, 2200));
					dl = 17'($urandom_range(0, 3));
					fg = 17'($urandom_range(2000, 70000));
					tg = 17'($urandom_range(0, 4000));
					ig = 17'($urandom_range(62000, 80000));
					if ($urandom_range(0, 3) == 0)
						pm = 17'($urandom);
					if ($urandom_range(0, 3) == 0)
						fg = 17'($urandom);
					if ($urandom_range(0, 3) == 0)
						tg = 17'($urandom);
				end
			endcase
			write_reg(REG_PRESS_MARGIN, pm);
			write_reg(REG_RELEASE_MARGIN, rm);
			write_reg(REG_DEBOUNCE_LIMIT, dl);
			write_reg(REG_FILTER_GAIN, fg);
			write_reg(REG_TRACK_GAIN, tg);
			write_reg(REG_INIT_GAIN, ig);
			if (ph > 4)
				write_reg(ph[0] ? REG_SPARE_A : REG_SPARE_B, 17'($urandom));
			cfg_write <= 1'b0;
			steady = ($urandom_range(0, 3) == 0);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 6 && n == PHASE_ITEMS / 2)
					wait_drain();
				// mostly a few pads that rest, get touched and let go
				p = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(0, 7);
				if ($urandom_range(0, 99) < 3)
					touch_on[p] = ~touch_on[p];
				if ($urandom_range(0, 199) == 0)
					rest_level[p] = $urandom_range(300, 30000);
				k = $urandom_range(0, 99);
				v = $urandom_range(0, 65535);
				cmd = CMD_EVALUATE;
				if (k < 5) begin
					cmd = CMD_UNKNOWN;
				end else if (k < 10) begin
					// noise samples, rails included
					cmd = CMD_SAMPLE;
					if (k == 5)
						v = 0;
					else if (k == 6)
						v = 65535;
				end else if (k < 15) begin
					cmd = CMD_CALIBRATE;
				end else if (k < 55) begin
					cmd = CMD_SAMPLE;
					v = rest_level[p] + (touch_on[p] ? lift[p] : 0)
						+ int'($urandom_range(0, 60)) - 30;
					if (v < 0)
						v = 0;
					if (v > 65535)
						v = 65535;
				end
				send_item(cmd, p[2:0], v[CNT_W-1:0]);
			end
		end

		wait_drain();
		if (board.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
design/tpbd_pkg.sv
design/tpbd_update.sv
design/touch_pad_baseline_detector.sv
tb/touch_board_pkg.sv
tb/tb.sv
